FILE: design/tmh_pkg.sv
// ----------------------------------------------------------------------------
// tmh_pkg
// Shared types and codes of the heap timer queue.
// ----------------------------------------------------------------------------
package tmh_pkg;

    localparam int TIME_W = 48;
    localparam int ID_W   = 32;
    localparam int PER_W  = 32;

    typedef enum logic [1:0] {
        ACT_ADD    = 2'd0,
        ACT_CANCEL = 2'd1,
        ACT_PROC   = 2'd2,
        ACT_NONE   = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        KIND_ADD_OK  = 2'd0,
        KIND_ADD_REJ = 2'd1,
        KIND_FIRED   = 2'd2,
        KIND_DONE    = 2'd3
    } t_kind;

    // one heap slot
    typedef struct packed {
        logic [TIME_W-1:0] expiry;
        logic [ID_W-1:0]   ident;
        logic [PER_W-1:0]  period;
        logic              live;
    } t_ent;

    localparam int ENT_W = $bits(t_ent);

    // shared time unit results
    typedef struct packed {
        logic [TIME_W-1:0] sum_sat;
        logic [TIME_W-1:0] diff;
        logic              le;
        logic              lt;
    } t_alu_res;

endpackage

FILE: design/tmh_alu.sv
// ----------------------------------------------------------------------------
// tmh_alu
// Shared time unit: saturating add, difference and compares on 48-bit times.
// ----------------------------------------------------------------------------
module tmh_alu
    import tmh_pkg::*;
(
    input  logic [TIME_W-1:0] i_a,
    input  logic [TIME_W-1:0] i_b,
    output t_alu_res          o_res
);

    logic [TIME_W:0] sum;

    // add with carry, clamp on overflow
    assign sum             = {1'b0, i_a} + {1'b0, i_b};
    assign o_res.sum_sat   = sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
    assign o_res.diff      = i_a - i_b;
    assign o_res.le        = (i_a <= i_b);
    assign o_res.lt        = (i_a < i_b);

endmodule

FILE: design/tmh_ram.sv
// ----------------------------------------------------------------------------
// tmh_ram
// Heap slot storage: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module tmh_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 113
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write slot
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read slot
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

FILE: design/timer_min_heap_scheduler.sv
// ----------------------------------------------------------------------------
// timer_min_heap_scheduler
// Timer queue kept as a binary min-heap on expiry time in one slot memory.
// ----------------------------------------------------------------------------
// Add: a sift up, one memory read a level.
// Cancel: one memory read per slot scanned, up to HEAP_DEPTH slots.
// Process: per top slot removed a sift down (two child reads a level),
// plus a sift up for a repeating timer.
// One word in flight; the single memory read port sets the pace.
// Synchronous active-low reset empties the heap and sets the next id to 1.
module timer_min_heap_scheduler
    import tmh_pkg::*;
#(
    parameter int HEAP_DEPTH = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [1:0]           i_action,
    input  logic [47:0]          i_now_time,
    input  logic [31:0]          i_delay,
    input  logic [31:0]          i_period,
    input  logic [31:0]          i_target_id,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [1:0]           o_kind,
    output logic [31:0]          o_timer_id,
    output logic signed [32:0]   o_next_wait,
    output logic [4:0]           o_active_count,
    output logic                 o_last
);

    localparam int AW = $clog2(HEAP_DEPTH);
    localparam int CW = $clog2(HEAP_DEPTH + 1);
    localparam int XW = AW + 2;

    typedef enum logic [4:0] {
        S_IDLE, S_UP, S_UP_CMP, S_UP_END, S_RM, S_RM_LD, S_DN, S_DN_L, S_DN_R,
        S_DN_CMP, S_RM_END, S_PR, S_PR_CHK, S_CAN_RD, S_CAN_CHK, S_OUT
    } t_state;

    t_state          r_state, r_after;
    t_ent            r_cur, r_lbuf, rd;
    logic [AW-1:0]   r_k, r_m;
    logic [CW-1:0]   r_tot, r_cnt, r_fires, r_i;
    logic [ID_W-1:0] r_id, r_fid;
    logic [PER_W-1:0] r_fper;
    logic [TIME_W-1:0] r_now;
    logic [ID_W-1:0] r_tgt;
    logic            r_ret_add, r_reins;
    // pending result word
    t_kind           r_pk;
    logic [31:0]     r_pid;
    logic [32:0]     r_pw;
    logic [CW-1:0]   r_pc;
    logic            r_pl;
    logic            r_ov;

    logic [TIME_W-1:0] alu_a, alu_b;
    t_alu_res          alu;
    logic              we, re;
    logic [AW-1:0]     waddr, raddr;
    t_ent              wdata;
    logic [ENT_W-1:0]  rdata;
    logic [XW-1:0]     l_idx, r_idx, tot_x;
    logic [CW-1:0]     tot_m1;
    logic [31:0]       wait_sat;

    assign rd     = t_ent'(rdata);
    assign l_idx  = XW'({r_k, 1'b1});
    assign r_idx  = l_idx + XW'(1);
    assign tot_x  = XW'(r_tot);
    assign tot_m1 = r_tot - CW'(1);
    assign wait_sat = (alu.diff[TIME_W-1:32] != '0) ? 32'hFFFF_FFFF : alu.diff[31:0];

    tmh_alu u_alu (
        .i_a   (alu_a),
        .i_b   (alu_b),
        .o_res (alu)
    );

    tmh_ram #(
        .DEPTH (HEAP_DEPTH),
        .WIDTH (ENT_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // steer the shared time unit
    always_comb begin
        alu_a = '0;
        alu_b = '0;
        unique case (r_state)
            S_IDLE: begin
                alu_a = i_now_time;
                alu_b = TIME_W'(i_delay);
            end
            S_RM_END: begin
                alu_a = r_now;
                alu_b = TIME_W'(r_fper);
            end
            S_UP_CMP: begin
                alu_a = rd.expiry;
                alu_b = r_cur.expiry;
            end
            S_DN_R: begin
                alu_a = rd.expiry;
                alu_b = r_lbuf.expiry;
            end
            S_DN_CMP: begin
                alu_a = r_cur.expiry;
                alu_b = r_lbuf.expiry;
            end
            S_PR_CHK: begin
                alu_a = rd.expiry;
                alu_b = r_now;
            end
            default: begin
            end
        endcase
    end

    // memory port control
    always_comb begin
        we    = 1'b0;
        re    = 1'b0;
        waddr = r_k;
        raddr = '0;
        wdata = r_cur;
        unique case (r_state)
            S_UP: begin
                if (r_k == '0) begin
                    we = 1'b1;
                end else begin
                    re    = 1'b1;
                    raddr = AW'((r_k - AW'(1)) >> 1);
                end
            end
            S_UP_CMP: begin
                we    = 1'b1;
                wdata = alu.le ? r_cur : rd;
            end
            S_RM: begin
                if (tot_m1 != '0) begin
                    re    = 1'b1;
                    raddr = tot_m1[AW-1:0];
                end
            end
            S_DN: begin
                if (l_idx >= tot_x) begin
                    we = 1'b1;
                end else begin
                    re    = 1'b1;
                    raddr = l_idx[AW-1:0];
                end
            end
            S_DN_L: begin
                if (r_idx < tot_x) begin
                    re    = 1'b1;
                    raddr = r_idx[AW-1:0];
                end
            end
            S_DN_CMP: begin
                we    = 1'b1;
                wdata = alu.le ? r_cur : r_lbuf;
            end
            S_PR: begin
                re = (r_tot != '0);
            end
            S_CAN_RD: begin
                re    = (r_i < r_tot);
                raddr = r_i[AW-1:0];
            end
            S_CAN_CHK: begin
                waddr      = r_i[AW-1:0];
                wdata      = rd;
                wdata.live = 1'b0;
                we         = (rd.ident == r_tgt);
            end
            default: begin
            end
        endcase
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_after <= S_IDLE;
            r_tot   <= '0;
            r_cnt   <= '0;
            r_id    <= 32'd1;
            r_ov    <= 1'b0;
            r_fires <= '0;
            r_reins <= 1'b0;
        end else begin
            // drop the output word once taken, unless a new one loads now
            if (r_ov && !i_stall && (r_state != S_OUT)) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    r_now   <= i_now_time;
                    r_tgt   <= i_target_id;
                    r_fires <= '0;
                    r_i     <= '0;
                    if (i_valid) begin
                        unique case (t_action'(i_action))
                            ACT_ADD: begin
                                r_pl    <= 1'b1;
                                r_pw    <= '0;
                                r_after <= S_IDLE;
                                if (r_tot >= CW'(HEAP_DEPTH)) begin
                                    r_pk    <= KIND_ADD_REJ;
                                    r_pid   <= '0;
                                    r_pc    <= r_cnt;
                                    r_state <= S_OUT;
                                end else begin
                                    r_pk      <= KIND_ADD_OK;
                                    r_pid     <= r_id;
                                    r_pc      <= r_cnt + CW'(1);
                                    r_cnt     <= r_cnt + CW'(1);
                                    r_tot     <= r_tot + CW'(1);
                                    r_k       <= r_tot[AW-1:0];
                                    r_cur     <= '{expiry: alu.sum_sat, ident: r_id,
                                                   period: i_period, live: 1'b1};
                                    r_id      <= (r_id == 32'hFFFF_FFFF) ? 32'd1
                                                                         : r_id + 32'd1;
                                    r_ret_add <= 1'b1;
                                    r_state   <= S_UP;
                                end
                            end
                            ACT_CANCEL: r_state <= S_CAN_RD;
                            ACT_PROC:   r_state <= S_PR;
                            ACT_NONE:   r_state <= S_IDLE;
                        endcase
                    end
                end
                // sift up: move parents down until the hole fits
                S_UP: begin
                    if (r_k == '0) begin
                        r_state <= S_UP_END;
                    end else begin
                        r_state <= S_UP_CMP;
                    end
                end
                S_UP_CMP: begin
                    if (alu.le) begin
                        r_state <= S_UP_END;
                    end else begin
                        r_k     <= AW'((r_k - AW'(1)) >> 1);
                        r_state <= S_UP;
                    end
                end
                S_UP_END: begin
                    r_state <= r_ret_add ? S_OUT : S_PR;
                end
                // remove top: pull last slot to the root and sift down
                S_RM: begin
                    r_tot   <= tot_m1;
                    r_k     <= '0;
                    r_state <= (tot_m1 == '0) ? S_RM_END : S_RM_LD;
                end
                S_RM_LD: begin
                    r_cur   <= rd;
                    r_state <= S_DN;
                end
                S_DN: begin
                    r_state <= (l_idx >= tot_x) ? S_RM_END : S_DN_L;
                end
                S_DN_L: begin
                    r_lbuf  <= rd;
                    r_m     <= l_idx[AW-1:0];
                    r_state <= (r_idx < tot_x) ? S_DN_R : S_DN_CMP;
                end
                S_DN_R: begin
                    if (alu.lt) begin
                        r_lbuf <= rd;
                        r_m    <= r_idx[AW-1:0];
                    end
                    r_state <= S_DN_CMP;
                end
                S_DN_CMP: begin
                    if (alu.le) begin
                        r_state <= S_RM_END;
                    end else begin
                        r_k     <= r_m;
                        r_state <= S_DN;
                    end
                end
                // put a repeating timer back in
                S_RM_END: begin
                    if (r_reins) begin
                        r_cur     <= '{expiry: alu.sum_sat, ident: r_fid,
                                       period: r_fper, live: 1'b1};
                        r_k       <= r_tot[AW-1:0];
                        r_tot     <= r_tot + CW'(1);
                        r_ret_add <= 1'b0;
                        r_state   <= S_UP;
                    end else begin
                        r_state <= S_PR;
                    end
                end
                S_PR: begin
                    if (r_tot == '0) begin
                        r_pk    <= KIND_DONE;
                        r_pid   <= '0;
                        r_pw    <= '1;
                        r_pc    <= r_cnt;
                        r_pl    <= 1'b1;
                        r_after <= S_IDLE;
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_PR_CHK;
                    end
                end
                // inspect the top slot
                S_PR_CHK: begin
                    if (!rd.live) begin
                        r_reins <= 1'b0;
                        r_state <= S_RM;
                    end else if (alu.le && (r_fires < CW'(HEAP_DEPTH))) begin
                        r_fid   <= rd.ident;
                        r_fper  <= rd.period;
                        r_reins <= (rd.period != '0);
                        r_fires <= r_fires + CW'(1);
                        r_cnt   <= r_cnt - CW'(rd.period == '0);
                        r_pk    <= KIND_FIRED;
                        r_pid   <= rd.ident;
                        r_pw    <= '0;
                        r_pc    <= r_cnt - CW'(rd.period == '0);
                        r_pl    <= 1'b0;
                        r_after <= S_RM;
                        r_state <= S_OUT;
                    end else begin
                        r_pk    <= KIND_DONE;
                        r_pid   <= '0;
                        r_pw    <= alu.le ? 33'd0 : {1'b0, wait_sat};
                        r_pc    <= r_cnt;
                        r_pl    <= 1'b1;
                        r_after <= S_IDLE;
                        r_state <= S_OUT;
                    end
                end
                // scan slots in storage order for the id
                S_CAN_RD: begin
                    r_state <= (r_i < r_tot) ? S_CAN_CHK : S_IDLE;
                end
                S_CAN_CHK: begin
                    if (rd.ident == r_tgt) begin
                        if (rd.live) begin
                            r_cnt <= r_cnt - CW'(1);
                        end
                        r_state <= S_IDLE;
                    end else begin
                        r_i     <= r_i + CW'(1);
                        r_state <= S_CAN_RD;
                    end
                end
                // hand the word to the output register once it is free
                S_OUT: begin
                    if (!r_ov || !i_stall) begin
                        r_ov           <= 1'b1;
                        o_kind         <= r_pk;
                        o_timer_id     <= r_pid;
                        o_next_wait    <= r_pw;
                        o_active_count <= 5'(r_pc);
                        o_last         <= r_pl;
                        r_state        <= r_after;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid = r_ov;
    assign o_stall = (r_state != S_IDLE);

    // a repeating timer being put back is counted active while out of the heap
    a_cnt_le_tot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_cnt} <= {1'b0, r_tot} + {{CW{1'b0}}, r_reins})
        else $error("active count above occupancy");
    a_tot_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tot <= CW'(HEAP_DEPTH)) else $error("heap occupancy overflow");
    a_id_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_id != '0) else $error("id counter reached zero");
    a_fire_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fires <= CW'(HEAP_DEPTH)) else $error("fire count above limit");

endmodule

FILE: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives add, cancel, process and no-op words into the heap timer queue under
// several idle and stall mixes, predicts every result with a behavioral
// min-heap and checks each result word field by field in order.
// ----------------------------------------------------------------------------
module tb_top;
    import tmh_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 16;
    localparam logic [47:0] TIME_TOP = 48'hFFFF_FFFF_FFFF;

    typedef struct {
        logic [1:0]  kind;
        logic [31:0] timer_id;
        logic [32:0] next_wait;
        logic [4:0]  active_count;
        logic        last;
    } t_res;

    // ------------------------------------------------------------------------
    // Scoreboard: behavioral heap plus queue of pending result words
    // ------------------------------------------------------------------------
    class heap_scoreboard;
        logic [47:0] exp_q[DEPTH];
        logic [31:0] id_q[DEPTH];
        logic [31:0] per_q[DEPTH];
        logic        live_q[DEPTH];
        int          used;
        logic [31:0] next_id;
        t_res        pending[$];
        int          errors;
        int          checked;
        int          fires;
        int          rejects;

        function new();
            used = 0;
            next_id = 1;
            errors = 0;
            checked = 0;
            fires = 0;
            rejects = 0;
        endfunction

        function logic [47:0] sat_sum(logic [47:0] a, logic [31:0] b);
            logic [48:0] s;
            s = {1'b0, a} + 49'(b);
            return s[48] ? TIME_TOP : s[47:0];
        endfunction

        function void swap(int a, int b);
            logic [47:0] e;
            logic [31:0] i;
            logic [31:0] p;
            logic        l;
            e = exp_q[a]; exp_q[a] = exp_q[b]; exp_q[b] = e;
            i = id_q[a]; id_q[a] = id_q[b]; id_q[b] = i;
            p = per_q[a]; per_q[a] = per_q[b]; per_q[b] = p;
            l = live_q[a]; live_q[a] = live_q[b]; live_q[b] = l;
        endfunction

        function void push(logic [47:0] e, logic [31:0] id, logic [31:0] p);
            int k;
            int par;
            k = used;
            exp_q[k] = e; id_q[k] = id; per_q[k] = p; live_q[k] = 1'b1;
            while (k > 0) begin
                par = (k - 1) / 2;
                if (exp_q[par] <= exp_q[k]) break;
                swap(par, k);
                k = par;
            end
            used++;
        endfunction

        function void pop_top();
            int k;
            int l;
            int m;
            k = 0;
            used--;
            if (used == 0) return;
            exp_q[0] = exp_q[used]; id_q[0] = id_q[used];
            per_q[0] = per_q[used]; live_q[0] = live_q[used];
            forever begin
                l = 2 * k + 1;
                m = l;
                if (l >= used) break;
                if (l + 1 < used && exp_q[l + 1] < exp_q[l]) m = l + 1;
                if (exp_q[k] <= exp_q[m]) break;
                swap(k, m);
                k = m;
            end
        endfunction

        function logic [4:0] live_total();
            int c;
            c = 0;
            for (int i = 0; i < used; i++) if (live_q[i]) c++;
            return c[4:0];
        endfunction

        function void emit(logic [1:0] kind, logic [31:0] id, logic [32:0] w,
                           logic last);
            t_res r;
            r.kind = kind; r.timer_id = id; r.next_wait = w;
            r.active_count = live_total(); r.last = last;
            pending.push_back(r);
        endfunction

        // note one accepted input word and queue its results
        function void note_word(logic [1:0] act, logic [47:0] now, logic [31:0] dly,
                                logic [31:0] per, logic [31:0] tgt);
            int nf;
            logic [31:0] fid;
            logic [31:0] fper;
            logic [47:0] d;
            logic [32:0] w;
            case (act)
                ACT_ADD: begin
                    if (used >= DEPTH) begin
                        rejects++;
                        emit(KIND_ADD_REJ, 32'd0, 33'd0, 1'b1);
                    end else begin
                        fid = next_id;
                        push(sat_sum(now, dly), fid, per);
                        next_id = (next_id == 32'hFFFF_FFFF) ? 32'd1 : next_id + 1;
                        emit(KIND_ADD_OK, fid, 33'd0, 1'b1);
                    end
                end
                ACT_CANCEL: begin
                    for (int i = 0; i < used; i++) begin
                        if (id_q[i] == tgt) begin
                            live_q[i] = 1'b0;
                            break;
                        end
                    end
                end
                ACT_PROC: begin
                    nf = 0;
                    while (used > 0) begin
                        if (!live_q[0]) begin
                            pop_top();
                            continue;
                        end
                        if (exp_q[0] <= now && nf < DEPTH) begin
                            fid = id_q[0];
                            fper = per_q[0];
                            pop_top();
                            if (fper != 0) push(sat_sum(now, fper), fid, fper);
                            nf++;
                            fires++;
                            emit(KIND_FIRED, fid, 33'd0, 1'b0);
                        end else begin
                            break;
                        end
                    end
                    if (used == 0) begin
                        w = '1;
                    end else if (exp_q[0] <= now) begin
                        w = '0;
                    end else begin
                        d = exp_q[0] - now;
                        w = (d > 48'hFFFF_FFFF) ? 33'h0_FFFF_FFFF : {1'b0, d[31:0]};
                    end
                    emit(KIND_DONE, 32'd0, w, 1'b1);
                end
                default: ;
            endcase
        endfunction

        function void report(string what, logic [32:0] got, logic [32:0] want);
            errors++;
            if (errors <= 40)
                $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
        endfunction

        // check one accepted result word against the oldest expectation
        function void check_word(t_res got);
            t_res want;
            if (pending.size() == 0) begin
                report("unexpected result word", {31'd0, got.kind}, 33'd0);
                return;
            end
            want = pending.pop_front();
            checked++;
            if (got.kind != want.kind)
                report("kind", 33'(got.kind), 33'(want.kind));
            if (got.timer_id != want.timer_id)
                report("timer_id", 33'(got.timer_id), 33'(want.timer_id));
            if (got.next_wait != want.next_wait)
                report("next_wait", got.next_wait, want.next_wait);
            if (got.active_count != want.active_count)
                report("active_count", 33'(got.active_count), 33'(want.active_count));
            if (got.last != want.last)
                report("last", 33'(got.last), 33'(want.last));
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [1:0]  i_action;
    logic [47:0] i_now_time;
    logic [31:0] i_delay;
    logic [31:0] i_period;
    logic [31:0] i_target_id;
    logic        o_valid;
    logic        i_stall;
    logic [1:0]  o_kind;
    logic [31:0] o_timer_id;
    logic signed [32:0] o_next_wait;
    logic [4:0]  o_active_count;
    logic        o_last;

    heap_scoreboard sb;
    int  idle_pct;
    int  stall_pct;
    logic [47:0] clock_ms;
    logic [31:0] last_id;

    timer_min_heap_scheduler #(.HEAP_DEPTH(DEPTH)) u_top (.*);

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // check every accepted result word
    always @(posedge i_clk) begin
        t_res r;
        if (i_rst_n && o_valid && !i_stall) begin
            r.kind = o_kind; r.timer_id = o_timer_id; r.next_wait = o_next_wait;
            r.active_count = o_active_count; r.last = o_last;
            sb.check_word(r);
        end
    end

    // random receiver stall, updated at the falling edge
    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(99) < stall_pct);
    end

    // send one word, holding it until accepted; valid stays up afterwards
    task automatic send_word(logic [1:0] act, logic [47:0] now, logic [31:0] dly,
                             logic [31:0] per, logic [31:0] tgt);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_action <= act;
        i_now_time <= now;
        i_delay <= dly;
        i_period <= per;
        i_target_id <= tgt;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_word(act, now, dly, per, tgt);
        if (act == ACT_ADD && sb.pending[$].kind == KIND_ADD_OK)
            last_id = sb.pending[$].timer_id;
        @(negedge i_clk);
    endtask

    // drop valid, wait for all results, then let a cancel settle
    task automatic drain();
        i_valid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    // one random well-formed word around the running clock
    task automatic random_word();
        int sel;
        logic [31:0] dly;
        logic [31:0] per;
        sel = $urandom_range(99);
        case ($urandom_range(3))
            0: dly = $urandom_range(50);
            1: dly = $urandom_range(2000);
            2: dly = $urandom;
            default: dly = 32'd0;
        endcase
        per = ($urandom_range(2) == 0) ? $urandom_range(300) :
              (($urandom_range(9) == 0) ? $urandom : 32'd0);
        if (sel < 45) begin
            send_word(ACT_ADD, clock_ms, dly, per, $urandom);
        end else if (sel < 60) begin
            send_word(ACT_CANCEL, 48'($urandom), $urandom, $urandom,
                      ($urandom_range(3) == 0) ? $urandom : last_id - $urandom_range(8));
        end else if (sel < 97) begin
            clock_ms = clock_ms + 48'($urandom_range(400));
            send_word(ACT_PROC, clock_ms, $urandom, $urandom, $urandom);
        end else begin
            send_word(ACT_NONE, 48'({$urandom, $urandom}), $urandom, $urandom, $urandom);
        end
    endtask

    initial begin
        #20_000_000;
        $display("tb_top: errors");
        $finish;
    end

    initial begin
        sb = new();
        idle_pct = 0;
        stall_pct = 0;
        clock_ms = 48'd1000;
        last_id = 32'd1;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_action = ACT_NONE;
        i_now_time = '0;
        i_delay = '0;
        i_period = '0;
        i_target_id = '0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: process on empty, extremes, overflow, fill past full
        send_word(ACT_PROC, 48'd0, 32'd0, 32'd0, 32'd0);
        send_word(ACT_ADD, TIME_TOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(ACT_ADD, 48'd0, 32'hFFFF_FFFF, 32'd0, 32'd0);
        send_word(ACT_PROC, 48'd0, 32'd0, 32'd0, 32'd0);
        send_word(ACT_CANCEL, 48'd0, 32'd0, 32'd0, 32'd2);
        send_word(ACT_CANCEL, 48'd0, 32'd0, 32'd0, 32'd2);
        send_word(ACT_CANCEL, 48'd0, 32'd0, 32'd0, 32'd99);
        send_word(ACT_NONE, TIME_TOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        for (int i = 0; i < 16; i++)
            send_word(ACT_ADD, 48'd10, 32'd5 * (i % 3), (i % 2) ? 32'd0 : 32'd1, 32'd0);
        // overdue saturated entry keeps firing up to the fire limit
        send_word(ACT_PROC, TIME_TOP, 32'd0, 32'd0, 32'd0);
        send_word(ACT_PROC, TIME_TOP, 32'd0, 32'd0, 32'd0);
        drain();
        // clear the heap by canceling all ids, then process
        for (int i = 1; i <= 20; i++) send_word(ACT_CANCEL, 48'd0, 32'd0, 32'd0, i);
        send_word(ACT_PROC, TIME_TOP, 32'd0, 32'd0, 32'd0);
        for (int i = 0; i < 17; i++) send_word(ACT_CANCEL, 48'd0, 32'd0, 32'd0, 32'd0);
        send_word(ACT_PROC, TIME_TOP, 32'd0, 32'd0, 32'd0);
        drain();

        // random phases with different idle and stall mixes
        for (int ph = 0; ph < 4; ph++) begin
            idle_pct  = (ph == 1 || ph == 3) ? ((ph == 3) ? 16 : 72) : 0;
            stall_pct = (ph == 2) ? 72 : ((ph == 3) ? 16 : 0);
            for (int n = 0; n < 100; n++) begin
                random_word();
                if (n == 60) drain();
            end
            drain();
        end
        idle_pct = 0;
        stall_pct = 0;
        drain();

        $display("tb_top: %0d result words checked, %0d fires, %0d full rejects",
                 sb.checked, sb.fires, sb.rejects);
        if (sb.errors == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end
endmodule

FILE: files.f
design/tmh_pkg.sv
design/tmh_alu.sv
design/tmh_ram.sv
design/timer_min_heap_scheduler.sv
verif/tb_top.sv
